/* rtl/core/awmu_pkg.sv */
// Shared types and constants for the atomic word memory unit.
`timescale 1ns / 1ps
package awmu_pkg;

    // access modes
    localparam logic [3:0] MODE_ADD      = 4'd0;
    localparam logic [3:0] MODE_SUB      = 4'd1;
    localparam logic [3:0] MODE_AND      = 4'd2;
    localparam logic [3:0] MODE_OR       = 4'd3;
    localparam logic [3:0] MODE_XOR      = 4'd4;
    localparam logic [3:0] MODE_LOAD     = 4'd5;
    localparam logic [3:0] MODE_STORE    = 4'd6;
    localparam logic [3:0] MODE_EXCHANGE = 4'd7;
    localparam logic [3:0] MODE_CMPXCHG  = 4'd8;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SIZE  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W         = 2;
    localparam logic [1:0] REG_ELEMENT_COUNT = 2'd0;
    localparam logic [1:0] REG_ELEMENT_BYTES = 2'd1;

    localparam int         CFG_DATA_W  = 11;
    localparam int         COUNT_W     = 11;
    localparam int         BYTES_W     = 4;
    localparam logic [3:0] WORD_BYTES  = 4'd4;
    localparam logic [3:0] BYTES_RESET = 4'd4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // classified access as it travels through the queue
    typedef struct packed {
        logic [3:0]  mode;
        logic [15:0] index;
        logic [31:0] value;
        logic [31:0] compare_value;
        logic [1:0]  status;
    } t_req;

endpackage

/* rtl/core/awmu_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module awmu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/awmu_queue.sv */
// Short FIFO of classified accesses between front and back.
`timescale 1ns / 1ps
module awmu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  awmu_pkg::t_req i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output awmu_pkg::t_req o_head
);

    awmu_pkg::t_req                  r_entry [awmu_pkg::QUEUE_DEPTH];
    logic [awmu_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [awmu_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [awmu_pkg::QCNT_W-1:0]     r_count;
    logic [awmu_pkg::QCNT_W-1:0]     n_count;

    assign o_full  = (r_count == awmu_pkg::QCNT_W'(awmu_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_entry[r_wr_ptr] <= i_data;
                r_wr_ptr          <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

/* rtl/core/awmu_front.sv */
// Front end: config registers, access acceptance and error classification.
`timescale 1ns / 1ps
module awmu_front #(
    parameter int DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [awmu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [awmu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [3:0]                        i_mode,
    input  logic [15:0]                       i_index,
    input  logic [31:0]                       i_value,
    input  logic [31:0]                       i_compare_value,
    input  logic                              i_clearing,
    input  logic                              i_full,
    output logic                              o_push,
    output awmu_pkg::t_req                    o_req
);

    logic [awmu_pkg::COUNT_W-1:0] r_element_count;
    logic [awmu_pkg::BYTES_W-1:0] r_element_bytes;
    logic                         n_range_bad;
    logic                         n_size_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= '0;
            r_element_bytes <= awmu_pkg::BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                awmu_pkg::REG_ELEMENT_COUNT: begin
                    r_element_count <= i_cfg_data[awmu_pkg::COUNT_W-1:0];
                end
                awmu_pkg::REG_ELEMENT_BYTES: begin
                    r_element_bytes <= i_cfg_data[awmu_pkg::BYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // index is checked first, element size only for an in-range index
    always_comb begin
        n_range_bad = ({5'd0, r_element_count} <= i_index)
                   || ({1'b0, i_index} >= 17'(DEPTH));
        n_size_bad  = (r_element_bytes != awmu_pkg::WORD_BYTES);
    end

    assign o_in_stall = i_clearing || i_full;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        o_req.mode          = i_mode;
        o_req.index         = i_index;
        o_req.value         = i_value;
        o_req.compare_value = i_compare_value;
        if (n_range_bad) begin
            o_req.status = awmu_pkg::ST_RANGE;
        end else if (n_size_bad) begin
            o_req.status = awmu_pkg::ST_SIZE;
        end else begin
            o_req.status = awmu_pkg::ST_OK;
        end
    end

endmodule

/* rtl/core/awmu_back.sv */
// Back end: read-modify-write sequencer over the word RAM, clear pass, result register.
`timescale 1ns / 1ps
module awmu_back #(
    parameter int DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  awmu_pkg::t_req i_head,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [31:0]    o_old_word,
    output logic [1:0]     o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_HOLD
    } t_state;

    t_state         r_state;
    awmu_pkg::t_req r_item;
    logic [AW-1:0]  r_clr_addr;
    logic [31:0]    r_res_word;
    logic [1:0]     r_res_status;
    logic           r_out_valid;
    logic [31:0]    r_old_word;
    logic [1:0]     r_status;

    logic           n_out_free;
    logic           n_out_valid;
    logic [AW-1:0]  n_addr;
    logic           n_we;
    logic [31:0]    n_wdata;
    logic [31:0]    n_word;
    logic [31:0]    n_result;
    logic [31:0]    w_rdata;

    awmu_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (n_wdata),
        .o_rdata (w_rdata)
    );

    assign n_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_clearing = (r_state == S_CLEAR);

    // result beat is held while stalled, loaded when the register frees up
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (n_out_free && (r_state inside {S_EXEC, S_HOLD})) begin
            n_out_valid = 1'b1;
        end
    end

    // new word and returned word for the item in flight
    always_comb begin
        n_word   = w_rdata;
        n_result = w_rdata;
        case (r_item.mode)
            awmu_pkg::MODE_ADD:      n_word = w_rdata + r_item.value;
            awmu_pkg::MODE_SUB:      n_word = w_rdata - r_item.value;
            awmu_pkg::MODE_AND:      n_word = w_rdata & r_item.value;
            awmu_pkg::MODE_OR:       n_word = w_rdata | r_item.value;
            awmu_pkg::MODE_XOR:      n_word = w_rdata ^ r_item.value;
            awmu_pkg::MODE_STORE: begin
                n_word   = r_item.value;
                n_result = r_item.value;
            end
            awmu_pkg::MODE_EXCHANGE: n_word = r_item.value;
            awmu_pkg::MODE_CMPXCHG: begin
                if (w_rdata == r_item.compare_value) begin
                    n_word = r_item.value;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_CLEAR: begin
                n_addr  = r_clr_addr;
                n_we    = 1'b1;
                n_wdata = '0;
            end
            S_IDLE: begin
                n_addr  = i_head.index[AW-1:0];
                n_we    = 1'b0;
                n_wdata = n_word;
            end
            S_EXEC: begin
                n_addr  = r_item.index[AW-1:0];
                n_we    = 1'b1;
                n_wdata = n_word;
            end
            default: begin
                n_addr  = r_item.index[AW-1:0];
                n_we    = 1'b0;
                n_wdata = n_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item <= i_head;
                        if (i_head.status == awmu_pkg::ST_OK) begin
                            r_state <= S_EXEC;
                        end else begin
                            // rejected access: no RAM write, old word reads as zero
                            r_res_word   <= '0;
                            r_res_status <= i_head.status;
                            r_state      <= S_HOLD;
                        end
                    end
                end
                S_EXEC: begin
                    if (n_out_free) begin
                        r_old_word  <= n_result;
                        r_status    <= awmu_pkg::ST_OK;
                        r_state     <= S_IDLE;
                    end else begin
                        r_res_word   <= n_result;
                        r_res_status <= awmu_pkg::ST_OK;
                        r_state      <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (n_out_free) begin
                        r_old_word  <= r_res_word;
                        r_status    <= r_res_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_old_word  = r_old_word;
    assign o_status    = r_status;

endmodule

/* rtl/core/atomic_word_memory_unit.sv */
// Atomic word memory unit: front classifies accesses, a two-beat queue feeds the RMW back end.
// An access passes the queue, then the back end's item register, then the result register.
// The back end reads then writes the single-port RAM for one access before taking the next.
// Reset: synchronous, active low; the word RAM is then zeroed one word a cycle,
// with input stalled meanwhile. element_count resets to 0, element_bytes to 4.
`timescale 1ns / 1ps
module atomic_word_memory_unit #(
    parameter int DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [awmu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [awmu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [3:0]                      i_mode,
    input  logic [15:0]                     i_index,
    input  logic signed [31:0]              i_value,
    input  logic signed [31:0]              i_compare_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [31:0]              o_old_word,
    output logic [1:0]                      o_status
);

    logic           w_push;
    awmu_pkg::t_req w_req;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    awmu_pkg::t_req w_head;
    logic           w_clearing;
    logic [31:0]    w_old_word;

    awmu_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_index         (i_index),
        .i_value         (i_value),
        .i_compare_value (i_compare_value),
        .i_clearing      (w_clearing),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_req           (w_req)
    );

    awmu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    awmu_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_old_word  (w_old_word),
        .o_status    (o_status)
    );

    assign o_old_word = signed'(w_old_word);

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the atomic word memory unit: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;

    localparam int         DEPTH         = 1024;
    localparam logic [1:0] REG_SPARE_2   = 2'd2;
    localparam logic [1:0] REG_SPARE_3   = 2'd3;
    localparam logic [3:0] MODE_SPARE_LO = 4'd9;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;
    localparam int         N_ROWS        = 31;
    localparam int         N_PHASES      = 10;

    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;
    localparam int STALL_COMB  = 3;

    typedef struct packed {
        logic [3:0]  mode;
        logic [15:0] index;
        logic [31:0] value;
        logic [31:0] compare_value;
    } t_access;

    typedef struct packed {
        logic [31:0] old_word;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [10:0] reg_data;
        t_access     acc;
        bit          typed;
        t_result     res;
    } t_row;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_cfg_we        = 1'b0;
    logic [awmu_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [awmu_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                            i_in_valid      = 1'b0;
    logic                            o_in_stall;
    logic [3:0]                      i_mode          = '0;
    logic [15:0]                     i_index         = '0;
    logic signed [31:0]              i_value         = '0;
    logic signed [31:0]              i_compare_value = '0;
    logic                            o_out_valid;
    logic                            i_out_stall     = 1'b0;
    logic signed [31:0]              o_old_word;
    logic [1:0]                      o_status;

    // shadow copy of the block's state
    logic [31:0]  shadow_words [DEPTH];
    logic [10:0]  shadow_count;
    logic [3:0]   shadow_bytes;

    t_result      pending_results [$];
    t_row         rows [N_ROWS];
    int           error_count = 0;
    int           burst_left  = 0;

    int phase_count [N_PHASES] = '{1024, 8, 1, 0, 1024, 300, 1024, 1024, 1024, 1023};
    int phase_bytes [N_PHASES] = '{4, 4, 4, 4, 1, 4, 0, 15, 8, 4};
    int phase_items [N_PHASES] = '{200, 120, 40, 30, 30, 150, 30, 30, 30, 240};

    atomic_word_memory_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_index         (i_index),
        .i_value         (i_value),
        .i_compare_value (i_compare_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_old_word      (o_old_word),
        .o_status        (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // performs one access on the shadow store and returns the result it gives
    function automatic t_result predict_access(input t_access a);
        t_result     r;
        logic [31:0] old;
        r.old_word = '0;
        r.status   = awmu_pkg::ST_OK;
        if (a.index >= shadow_count || a.index >= DEPTH) begin
            r.status = awmu_pkg::ST_RANGE;
        end else if (shadow_bytes != awmu_pkg::WORD_BYTES) begin
            r.status = awmu_pkg::ST_SIZE;
        end else begin
            old        = shadow_words[a.index];
            r.old_word = old;
            case (a.mode)
                awmu_pkg::MODE_ADD:      shadow_words[a.index] = old + a.value;
                awmu_pkg::MODE_SUB:      shadow_words[a.index] = old - a.value;
                awmu_pkg::MODE_AND:      shadow_words[a.index] = old & a.value;
                awmu_pkg::MODE_OR:       shadow_words[a.index] = old | a.value;
                awmu_pkg::MODE_XOR:      shadow_words[a.index] = old ^ a.value;
                awmu_pkg::MODE_STORE: begin
                    shadow_words[a.index] = a.value;
                    r.old_word            = a.value;
                end
                awmu_pkg::MODE_EXCHANGE: shadow_words[a.index] = a.value;
                awmu_pkg::MODE_CMPXCHG: begin
                    if (old == a.compare_value) shadow_words[a.index] = a.value;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic t_row acc_row(input logic [3:0] m, input logic [15:0] idx,
                                     input logic [31:0] v, input logic [31:0] c);
        t_row r;
        r       = '0;
        r.acc   = '{mode: m, index: idx, value: v, compare_value: c};
        return r;
    endfunction

    function automatic t_row chk_row(input logic [3:0] m, input logic [15:0] idx,
                                     input logic [31:0] v, input logic [31:0] c,
                                     input logic [31:0] old, input logic [1:0] st);
        t_row r;
        r       = acc_row(m, idx, v, c);
        r.typed = 1'b1;
        r.res   = '{old_word: old, status: st};
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [1:0] idx, input logic [10:0] data);
        t_row r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        if ($urandom_range(0, 99) >= 15) return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // mostly in-range traffic with a hot set of a few words, some far out of range
    function automatic t_access random_access();
        t_access a;
        int      pick;
        int      lim;
        lim  = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
        pick = $urandom_range(0, 99);
        if (pick < 85)
            a.mode = 4'($urandom_range(awmu_pkg::MODE_ADD, awmu_pkg::MODE_CMPXCHG));
        else
            a.mode = 4'($urandom_range(awmu_pkg::MODE_ADD, MODE_SPARE_HI));
        pick = $urandom_range(0, 99);
        if (lim == 0 || pick >= 85)
            a.index = 16'($urandom_range(0, 65535));
        else if (pick >= 78)
            a.index = 16'(shadow_count);
        else if (pick < 45)
            a.index = 16'($urandom_range(0, ((lim < 4) ? lim : 4) - 1));
        else
            a.index = 16'($urandom_range(0, lim - 1));
        a.value         = random_word();
        a.compare_value = random_word();
        // steer compare-exchange towards a hit half the time
        if (a.mode == awmu_pkg::MODE_CMPXCHG && a.index < lim && $urandom_range(0, 1) == 1)
            a.compare_value = shadow_words[a.index];
        return a;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            awmu_pkg::REG_ELEMENT_COUNT: shadow_count = data;
            awmu_pkg::REG_ELEMENT_BYTES: shadow_bytes = data[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_access(input t_access a, input bit typed, input t_result typed_res);
        int      gap;
        t_result predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_mode          <= a.mode;
        i_index         <= a.index;
        i_value         <= a.value;
        i_compare_value <= a.compare_value;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = predict_access(a);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // receiver stall pattern: switches among none, light, heavy and periodic stalling over random spans
    initial begin
        int style;
        int span;
        int tick;
        tick = 0;
        forever begin
            style = $urandom_range(STALL_NONE, STALL_COMB);
            span  = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                tick++;
                case (style)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 75);
                    default:     i_out_stall <= (tick % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: old_word %h status %0d", o_old_word, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_old_word !== want.old_word) begin
                    $error("old_word: expected %h, actual %h", want.old_word, o_old_word);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        foreach (shadow_words[k]) shadow_words[k] = '0;
        shadow_count = '0;
        shadow_bytes = awmu_pkg::BYTES_RESET;

        rows = '{
            // nothing in use yet
            chk_row(awmu_pkg::MODE_LOAD, 16'd0, 32'h0, 32'h0, 32'h0, awmu_pkg::ST_RANGE),
            cfg_row(awmu_pkg::REG_ELEMENT_COUNT, 11'd1024),
            // cleared by reset
            chk_row(awmu_pkg::MODE_LOAD, 16'd1023, 32'h0, 32'h0, 32'h0, awmu_pkg::ST_OK),
            chk_row(awmu_pkg::MODE_STORE, 16'd1024, 32'h1, 32'h0, 32'h0, awmu_pkg::ST_RANGE),
            chk_row(awmu_pkg::MODE_XOR, 16'hFFFF, '1, '1, 32'h0, awmu_pkg::ST_RANGE),
            chk_row(awmu_pkg::MODE_STORE, 16'd0, 32'h7FFF_FFFF, 32'h0,
                    32'h7FFF_FFFF, awmu_pkg::ST_OK),
            acc_row(awmu_pkg::MODE_ADD, 16'd0, 32'h1, 32'h0),             // wraps to min
            acc_row(awmu_pkg::MODE_LOAD, 16'd0, 32'h0, 32'h0),
            acc_row(awmu_pkg::MODE_SUB, 16'd1, 32'h8000_0000, 32'h0),
            acc_row(awmu_pkg::MODE_SUB, 16'd1, 32'h1, 32'h0),
            acc_row(awmu_pkg::MODE_AND, 16'd0, 32'hFFFF_0001, 32'h0),
            acc_row(awmu_pkg::MODE_OR, 16'd2, 32'hA5A5_5A5A, 32'h0),
            acc_row(awmu_pkg::MODE_XOR, 16'd2, '1, 32'h0),
            acc_row(awmu_pkg::MODE_EXCHANGE, 16'd3, 32'h8000_0000, 32'h0),
            acc_row(awmu_pkg::MODE_CMPXCHG, 16'd3, 32'h1234_5678, 32'h8000_0000), // hit
            acc_row(awmu_pkg::MODE_CMPXCHG, 16'd3, 32'h0000_0001, 32'h8000_0000), // miss
            acc_row(MODE_SPARE_HI, 16'd3, '1, '1),
            acc_row(MODE_SPARE_LO, 16'd2, 32'h5555_5555, 32'h0),
            chk_row(awmu_pkg::MODE_STORE, 16'd1023, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, awmu_pkg::ST_OK),
            cfg_row(awmu_pkg::REG_ELEMENT_BYTES, 11'd8),
            chk_row(awmu_pkg::MODE_LOAD, 16'd0, 32'h0, 32'h0, 32'h0, awmu_pkg::ST_SIZE),
            // range wins over size
            chk_row(awmu_pkg::MODE_STORE, 16'd1024, '1, 32'h0, 32'h0, awmu_pkg::ST_RANGE),
            cfg_row(REG_SPARE_2, 11'd0),
            chk_row(awmu_pkg::MODE_ADD, 16'd5, 32'h1, 32'h0, 32'h0, awmu_pkg::ST_SIZE),
            cfg_row(REG_SPARE_3, 11'h7FF),
            cfg_row(awmu_pkg::REG_ELEMENT_BYTES, 11'd4),
            acc_row(awmu_pkg::MODE_LOAD, 16'd3, 32'h0, 32'h0),
            cfg_row(awmu_pkg::REG_ELEMENT_COUNT, 11'd1),
            chk_row(awmu_pkg::MODE_LOAD, 16'd1, 32'h0, 32'h0, 32'h0, awmu_pkg::ST_RANGE),
            acc_row(awmu_pkg::MODE_LOAD, 16'd0, 32'h0, 32'h0),
            chk_row(awmu_pkg::MODE_EXCHANGE, 16'd1023, 32'h0, 32'h0, 32'h0,
                    awmu_pkg::ST_RANGE)
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                wait_drained();
                write_reg(rows[r].reg_idx, rows[r].reg_data);
            end else begin
                send_access(rows[r].acc, rows[r].typed, rows[r].res);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            write_reg(awmu_pkg::REG_ELEMENT_COUNT, 11'(phase_count[p]));
            write_reg(awmu_pkg::REG_ELEMENT_BYTES, {7'($urandom), 4'(phase_bytes[p])});
            write_reg((p % 2 == 1) ? REG_SPARE_3 : REG_SPARE_2, 11'($urandom));
            repeat (phase_items[p]) send_access(random_access(), 1'b0, '0);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/awmu_pkg.sv
rtl/core/awmu_ram.sv
rtl/core/awmu_queue.sv
rtl/core/awmu_front.sv
rtl/core/awmu_back.sv
rtl/core/atomic_word_memory_unit.sv
dv/tb_top.sv
